// ===== hdl/pixel_modulation_bin_gate_core_assert.svh =====
// assertion macros shared by the bin gate rtl
`ifndef PIXEL_MODULATION_BIN_GATE_CORE_ASSERT_SVH
`define PIXEL_MODULATION_BIN_GATE_CORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define PMBG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pmbg assertion failed");

// consequent checked in the cycle after the antecedent
`define PMBG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmbg assertion failed");

`endif

// ===== hdl/pmbg_pkg.sv =====
// types and constants of the pixel modulation bin gate
`default_nettype none

package pmbg_pkg;

    // field widths of the channels
    localparam int SAMPLE_W  = 8;
    localparam int BIN_W     = 10;
    localparam int POWER_W   = 19;
    localparam int AC_OUT_W  = 20;
    localparam int POWMIN_W  = 20;
    localparam int PURITY_W  = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 20;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_MIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PURITY_MIN = 2'd1;

    // configuration reset values
    localparam logic [POWMIN_W-1:0] POWER_MIN_RST  = 20'd1000;
    localparam logic [PURITY_W-1:0] PURITY_MIN_RST = 17'd32768;

    // output saturation limits
    localparam int BIN_LIMIT   = 510;
    localparam int POWER_LIMIT = 520200;
    localparam int AC_LIMIT    = 1040400;

    // purity compares 2*power in q16 against the threshold times ac
    localparam int PURITY_SHIFT = 17;

    // coefficient format and rounding
    localparam int    COEF_W        = 16;
    localparam int    Q14_SHIFT     = 14;
    localparam int    ROUND_Q14     = 8192;
    localparam longint Q14_ONE      = 64'sd16384;
    localparam longint Q30_ONE      = 64'sd1073741824;
    localparam longint PI_Q30       = 64'sd3373259426;
    localparam longint Q30_TO_Q14_RND = 64'sd32768;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MRE,
        ST_MIM,
        ST_MSQ,
        ST_ACQ,
        ST_RND,
        ST_PRE,
        ST_PIM,
        ST_PSS,
        ST_PNQ,
        ST_PAC,
        ST_PUR,
        ST_GATE
    } pmbg_state_t;

endpackage

`default_nettype wire

// ===== hdl/pmbg_if.sv =====
// request channel interfaces of the bin gate: samples, results, configuration
`default_nettype none

interface pmbg_in_if;
    logic                           valid;
    logic                           ready;
    logic [pmbg_pkg::SAMPLE_W-1:0]  sample;
    logic                           window_start;

    modport source (output valid, sample, window_start, input ready);
    modport sink   (input valid, sample, window_start, output ready);
endinterface

interface pmbg_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [pmbg_pkg::BIN_W-1:0]    bin_real;
    logic signed [pmbg_pkg::BIN_W-1:0]    bin_imag;
    logic [pmbg_pkg::POWER_W-1:0]         bin_power;
    logic [pmbg_pkg::AC_OUT_W-1:0]        ac_scaled;
    logic                                 power_pass;
    logic                                 purity_pass;
    logic                                 detected;

    modport source (output valid, bin_real, bin_imag, bin_power, ac_scaled,
                    power_pass, purity_pass, detected, input ready);
    modport sink   (input valid, bin_real, bin_imag, bin_power, ac_scaled,
                    power_pass, purity_pass, detected, output ready);
endinterface

interface pmbg_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [pmbg_pkg::CFG_IDX_W-1:0]    index;
    logic [pmbg_pkg::CFG_DAT_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/pmbg_mul.sv =====
// shared signed multiplier with registered product
`default_nettype none

module pmbg_mul #(
    parameter int A_W = 18,
    parameter int B_W = 24
) (
    input  wire logic                     clk,
    input  wire logic signed [A_W-1:0]    a,
    input  wire logic signed [B_W-1:0]    b,
    output logic signed [A_W+B_W-1:0]     p_reg
);

    logic signed [A_W+B_W-1:0] p_next;

    assign p_next = (A_W+B_W)'(a) * (A_W+B_W)'(b);

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

endmodule

`default_nettype wire

// ===== hdl/pmbg_rom.sv =====
// bin-2 coefficient table, cos and -sin in q1.14, built at elaboration
`default_nettype none

module pmbg_rom #(
    parameter int WINDOW = 8,
    localparam int IDX_W = $clog2(WINDOW)
) (
    input  wire logic [IDX_W-1:0]                    pos,
    output logic signed [pmbg_pkg::COEF_W-1:0]       cos_q14,
    output logic signed [pmbg_pkg::COEF_W-1:0]       nsin_q14
);

    logic signed [pmbg_pkg::COEF_W-1:0] cos_tab  [WINDOW];
    logic signed [pmbg_pkg::COEF_W-1:0] nsin_tab [WINDOW];

    for (genvar n = 0; n < WINDOW; n++)
    begin : g_coef
        // fold the angle into the first quadrant
        localparam longint K  = (2 * n) % WINDOW;
        localparam longint Q  = (4 * K) / WINDOW;
        localparam longint R  = 4 * K - Q * WINDOW;
        localparam longint A  = (R * pmbg_pkg::PI_Q30) / (2 * WINDOW);
        localparam longint X2 = (A * A) >>> 30;

        // seven taylor terms in q30
        localparam longint TS1 = ((A   * X2) >>> 30) / 6;
        localparam longint TS2 = ((TS1 * X2) >>> 30) / 20;
        localparam longint TS3 = ((TS2 * X2) >>> 30) / 42;
        localparam longint TS4 = ((TS3 * X2) >>> 30) / 72;
        localparam longint TS5 = ((TS4 * X2) >>> 30) / 110;
        localparam longint TS6 = ((TS5 * X2) >>> 30) / 156;
        localparam longint TS7 = ((TS6 * X2) >>> 30) / 210;
        localparam longint TC1 = ((pmbg_pkg::Q30_ONE * X2) >>> 30) / 2;
        localparam longint TC2 = ((TC1 * X2) >>> 30) / 12;
        localparam longint TC3 = ((TC2 * X2) >>> 30) / 30;
        localparam longint TC4 = ((TC3 * X2) >>> 30) / 56;
        localparam longint TC5 = ((TC4 * X2) >>> 30) / 90;
        localparam longint TC6 = ((TC5 * X2) >>> 30) / 132;
        localparam longint TC7 = ((TC6 * X2) >>> 30) / 182;
        localparam longint SS  = A - TS1 + TS2 - TS3 + TS4 - TS5 + TS6 - TS7;
        localparam longint CC  = pmbg_pkg::Q30_ONE - TC1 + TC2 - TC3 + TC4 - TC5 + TC6 - TC7;

        // q30 to q14, rounded half up and held to [0, 1]
        localparam longint SR = (SS < 0) ? 0 : ((SS + pmbg_pkg::Q30_TO_Q14_RND) >>> 16);
        localparam longint CR = (CC < 0) ? 0 : ((CC + pmbg_pkg::Q30_TO_Q14_RND) >>> 16);
        localparam longint S14 = (SR > pmbg_pkg::Q14_ONE) ? pmbg_pkg::Q14_ONE : SR;
        localparam longint C14 = (CR > pmbg_pkg::Q14_ONE) ? pmbg_pkg::Q14_ONE : CR;

        // back to the full circle
        localparam longint CV = (Q == 0) ? C14 : (Q == 1) ? -S14 : (Q == 2) ? -C14 : S14;
        localparam longint SV = (Q == 0) ? S14 : (Q == 1) ? C14 : (Q == 2) ? -S14 : -C14;

        assign cos_tab[n]  = pmbg_pkg::COEF_W'(CV);
        assign nsin_tab[n] = pmbg_pkg::COEF_W'(-SV);
    end

    assign cos_q14  = cos_tab[pos];
    assign nsin_q14 = nsin_tab[pos];

endmodule

`default_nettype wire

// ===== hdl/pixel_modulation_bin_gate_core.sv =====
// Bin-2 lock-in detector for one pixel. Grey-level samples come in one per
// request, oldest first; window_start restarts the window. A new sample
// is not taken until the last one is through, since the single shared
// multiplier forms three products per sample (x*cos, x*-sin, x*x), one per
// cycle, with a registered product. After the last sample of a window is
// accumulated, the same multiplier forms re^2, im^2, sum^2, WINDOW*sumsq
// and the purity product in turn, and the result is then loaded into the
// output register. A result waiting there does not block further samples
// until the next window end. Configuration writes are taken in any cycle
// and are meant to be issued while the block is idle.
`default_nettype none
`include "pixel_modulation_bin_gate_core_assert.svh"

module pixel_modulation_bin_gate_core #(
    parameter int WINDOW = 8
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    pmbg_in_if.sink      samples,
    pmbg_out_if.source   results,
    pmbg_cfg_if.sink     cfg
);

    localparam int LW    = $clog2(WINDOW);
    localparam int ACC_W = LW + 24;
    localparam int RND_W = ACC_W - 13;
    localparam int SUM_W = LW + pmbg_pkg::SAMPLE_W;
    localparam int SQ_W  = LW + 2 * pmbg_pkg::SAMPLE_W;
    localparam int PW_W  = 2 * LW + 18;
    localparam int AC_W  = 2 * LW + 17;
    localparam int MA_W  = (RND_W > pmbg_pkg::PURITY_W + 1) ? RND_W : pmbg_pkg::PURITY_W + 1;
    localparam int MB_W  = AC_W + 1;
    localparam int P_W   = MA_W + MB_W;

    localparam logic [LW-1:0] LAST_POS = LW'(WINDOW - 1);
    localparam logic signed [RND_W-1:0] RE_HI = RND_W'(pmbg_pkg::BIN_LIMIT);
    localparam logic signed [RND_W-1:0] RE_LO = -RND_W'(pmbg_pkg::BIN_LIMIT);

    pmbg_pkg::pmbg_state_t state_reg, state_next;

    logic [pmbg_pkg::POWMIN_W-1:0]  power_min_reg;
    logic [pmbg_pkg::PURITY_W-1:0]  purity_min_reg;

    logic [LW-1:0]                  pos_reg;
    logic signed [ACC_W-1:0]        acc_re_reg;
    logic signed [ACC_W-1:0]        acc_im_reg;
    logic [SUM_W-1:0]               sum_reg;
    logic [SQ_W-1:0]                sq_reg;
    logic [pmbg_pkg::SAMPLE_W-1:0]  x_reg;
    logic signed [RND_W-1:0]        re_reg, re_next;
    logic signed [RND_W-1:0]        im_reg, im_next;
    logic [PW_W-1:0]                pw_reg;
    logic [AC_W-1:0]                ac_reg;
    logic                           out_valid_reg;

    logic signed [MA_W-1:0]         mul_a;
    logic signed [MB_W-1:0]         mul_b;
    logic signed [P_W-1:0]          prod_reg;
    logic signed [pmbg_pkg::COEF_W-1:0] cos_q14, nsin_q14;

    logic                           accept;
    logic                           last_pos;
    logic                           gate_fire;
    logic signed [ACC_W-1:0]        mag_re, mag_im, rnd_re, rnd_im;
    logic signed [P_W-1:0]          ac_diff;
    logic                           power_ok, purity_ok;
    logic [P_W-1:0]                 pw_scaled;

    pmbg_rom #(
        .WINDOW (WINDOW)
    ) u_rom (
        .pos      (pos_reg),
        .cos_q14  (cos_q14),
        .nsin_q14 (nsin_q14)
    );

    pmbg_mul #(
        .A_W (MA_W),
        .B_W (MB_W)
    ) u_mul (
        .clk   (clk),
        .a     (mul_a),
        .b     (mul_b),
        .p_reg (prod_reg)
    );

    assign accept    = samples.valid && samples.ready;
    assign last_pos  = (pos_reg == LAST_POS);
    assign gate_fire = (state_reg == pmbg_pkg::ST_GATE) && (!out_valid_reg || results.ready);
    assign cfg.ready = 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pmbg_pkg::ST_IDLE: if (samples.valid) state_next = pmbg_pkg::ST_MRE;
            pmbg_pkg::ST_MRE:  state_next = pmbg_pkg::ST_MIM;
            pmbg_pkg::ST_MIM:  state_next = pmbg_pkg::ST_MSQ;
            pmbg_pkg::ST_MSQ:  state_next = pmbg_pkg::ST_ACQ;
            pmbg_pkg::ST_ACQ:  state_next = last_pos ? pmbg_pkg::ST_RND : pmbg_pkg::ST_IDLE;
            pmbg_pkg::ST_RND:  state_next = pmbg_pkg::ST_PRE;
            pmbg_pkg::ST_PRE:  state_next = pmbg_pkg::ST_PIM;
            pmbg_pkg::ST_PIM:  state_next = pmbg_pkg::ST_PSS;
            pmbg_pkg::ST_PSS:  state_next = pmbg_pkg::ST_PNQ;
            pmbg_pkg::ST_PNQ:  state_next = pmbg_pkg::ST_PAC;
            pmbg_pkg::ST_PAC:  state_next = pmbg_pkg::ST_PUR;
            pmbg_pkg::ST_PUR:  state_next = pmbg_pkg::ST_GATE;
            pmbg_pkg::ST_GATE: if (gate_fire) state_next = pmbg_pkg::ST_IDLE;
            default:           state_next = pmbg_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs: handshake and multiplier operands
    always_comb
    begin
        samples.ready = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        unique case (state_reg)
            pmbg_pkg::ST_IDLE: samples.ready = 1'b1;
            pmbg_pkg::ST_MRE:
            begin
                mul_a = MA_W'($signed({1'b0, x_reg}));
                mul_b = MB_W'(cos_q14);
            end
            pmbg_pkg::ST_MIM:
            begin
                mul_a = MA_W'($signed({1'b0, x_reg}));
                mul_b = MB_W'(nsin_q14);
            end
            pmbg_pkg::ST_MSQ:
            begin
                mul_a = MA_W'($signed({1'b0, x_reg}));
                mul_b = MB_W'($signed({1'b0, x_reg}));
            end
            pmbg_pkg::ST_PRE:
            begin
                mul_a = MA_W'(re_reg);
                mul_b = MB_W'(re_reg);
            end
            pmbg_pkg::ST_PIM:
            begin
                mul_a = MA_W'(im_reg);
                mul_b = MB_W'(im_reg);
            end
            pmbg_pkg::ST_PSS:
            begin
                mul_a = MA_W'($signed({1'b0, sum_reg}));
                mul_b = MB_W'($signed({1'b0, sum_reg}));
            end
            pmbg_pkg::ST_PNQ:
            begin
                mul_a = MA_W'(WINDOW);
                mul_b = MB_W'($signed({1'b0, sq_reg}));
            end
            pmbg_pkg::ST_PUR:
            begin
                mul_a = MA_W'($signed({1'b0, purity_min_reg}));
                mul_b = MB_W'($signed({1'b0, ac_reg}));
            end
            pmbg_pkg::ST_GATE:
            begin
                // keep the purity product while the result waits
                mul_a = MA_W'($signed({1'b0, purity_min_reg}));
                mul_b = MB_W'($signed({1'b0, ac_reg}));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // rounding of the q14 sums, half away from zero
    always_comb
    begin
        mag_re  = acc_re_reg[ACC_W-1] ? -acc_re_reg : acc_re_reg;
        mag_im  = acc_im_reg[ACC_W-1] ? -acc_im_reg : acc_im_reg;
        rnd_re  = (mag_re + ACC_W'(pmbg_pkg::ROUND_Q14)) >>> pmbg_pkg::Q14_SHIFT;
        rnd_im  = (mag_im + ACC_W'(pmbg_pkg::ROUND_Q14)) >>> pmbg_pkg::Q14_SHIFT;
        re_next = RND_W'(acc_re_reg[ACC_W-1] ? -rnd_re : rnd_re);
        im_next = RND_W'(acc_im_reg[ACC_W-1] ? -rnd_im : rnd_im);
    end

    assign ac_diff   = prod_reg - P_W'($signed({1'b0, ac_reg}));
    assign pw_scaled = P_W'({pw_reg, {pmbg_pkg::PURITY_SHIFT{1'b0}}});
    assign power_ok  = pw_reg > PW_W'(power_min_reg);
    // the purity product is never negative
    assign purity_ok = pw_scaled > $unsigned(prod_reg);

    // control state, window accumulators and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pmbg_pkg::ST_IDLE;
            power_min_reg  <= pmbg_pkg::POWER_MIN_RST;
            purity_min_reg <= pmbg_pkg::PURITY_MIN_RST;
            pos_reg        <= '0;
            acc_re_reg     <= '0;
            acc_im_reg     <= '0;
            sum_reg        <= '0;
            sq_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid)
            begin
                unique case (cfg.index)
                    pmbg_pkg::CFG_POWER_MIN:  power_min_reg  <= cfg.data[pmbg_pkg::POWMIN_W-1:0];
                    pmbg_pkg::CFG_PURITY_MIN: purity_min_reg <= cfg.data[pmbg_pkg::PURITY_W-1:0];
                    default: ;
                endcase
            end

            if (gate_fire)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                pmbg_pkg::ST_IDLE:
                begin
                    // window restart drops any partial window
                    if (accept && samples.window_start)
                    begin
                        pos_reg    <= '0;
                        acc_re_reg <= '0;
                        acc_im_reg <= '0;
                        sum_reg    <= '0;
                        sq_reg     <= '0;
                    end
                end
                pmbg_pkg::ST_MIM: acc_re_reg <= acc_re_reg + ACC_W'(prod_reg);
                pmbg_pkg::ST_MSQ:
                begin
                    acc_im_reg <= acc_im_reg + ACC_W'(prod_reg);
                    sum_reg    <= sum_reg + SUM_W'(x_reg);
                end
                pmbg_pkg::ST_ACQ:
                begin
                    sq_reg <= sq_reg + SQ_W'(prod_reg);
                    if (!last_pos)
                        pos_reg <= pos_reg + 1'b1;
                end
                pmbg_pkg::ST_GATE:
                begin
                    if (gate_fire)
                    begin
                        pos_reg    <= '0;
                        acc_re_reg <= '0;
                        acc_im_reg <= '0;
                        sum_reg    <= '0;
                        sq_reg     <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            x_reg <= samples.sample;
        case (state_reg)
            pmbg_pkg::ST_RND:
            begin
                re_reg <= re_next;
                im_reg <= im_next;
            end
            pmbg_pkg::ST_PIM: pw_reg <= PW_W'(prod_reg);
            pmbg_pkg::ST_PSS: pw_reg <= pw_reg + PW_W'(prod_reg);
            pmbg_pkg::ST_PNQ: ac_reg <= AC_W'(prod_reg);
            pmbg_pkg::ST_PAC: ac_reg <= ac_diff[P_W-1] ? '0 : AC_W'(ac_diff);
            default: ;
        endcase
        if (gate_fire)
        begin
            if (re_reg > RE_HI)
                results.bin_real <= pmbg_pkg::BIN_W'(pmbg_pkg::BIN_LIMIT);
            else if (re_reg < RE_LO)
                results.bin_real <= -pmbg_pkg::BIN_W'(pmbg_pkg::BIN_LIMIT);
            else
                results.bin_real <= pmbg_pkg::BIN_W'(re_reg);
            if (im_reg > RE_HI)
                results.bin_imag <= pmbg_pkg::BIN_W'(pmbg_pkg::BIN_LIMIT);
            else if (im_reg < RE_LO)
                results.bin_imag <= -pmbg_pkg::BIN_W'(pmbg_pkg::BIN_LIMIT);
            else
                results.bin_imag <= pmbg_pkg::BIN_W'(im_reg);
            if (pw_reg > PW_W'(pmbg_pkg::POWER_LIMIT))
                results.bin_power <= pmbg_pkg::POWER_W'(pmbg_pkg::POWER_LIMIT);
            else
                results.bin_power <= pmbg_pkg::POWER_W'(pw_reg);
            if (ac_reg > AC_W'(pmbg_pkg::AC_LIMIT))
                results.ac_scaled <= pmbg_pkg::AC_OUT_W'(pmbg_pkg::AC_LIMIT);
            else
                results.ac_scaled <= pmbg_pkg::AC_OUT_W'(ac_reg);
            results.power_pass  <= power_ok;
            results.purity_pass <= purity_ok;
            results.detected    <= power_ok && purity_ok;
        end
    end

    assign results.valid = out_valid_reg;

    `PMBG_ASSERT_NEXT(a_accept_starts_mul, clk, rst_n, accept, state_reg == pmbg_pkg::ST_MRE)
    `PMBG_ASSERT_NEXT(a_gate_loads_result, clk, rst_n, gate_fire, out_valid_reg)
    `PMBG_ASSERT_SAME(a_pos_in_window, clk, rst_n, 1'b1, pos_reg <= LAST_POS)
    `PMBG_ASSERT_SAME(a_power_pass_nonzero, clk, rst_n, results.valid && results.power_pass, results.bin_power != '0)
    `PMBG_ASSERT_NEXT(a_last_goes_final, clk, rst_n, (state_reg == pmbg_pkg::ST_ACQ) && last_pos, state_reg == pmbg_pkg::ST_RND)

endmodule

`default_nettype wire

// ===== tb/pixel_modulation_bin_gate_core_test.sv =====
// testbench for the bin-2 lock-in detector: random sample windows, gate checks against a predictor
`timescale 1ns / 100ps

module pixel_modulation_bin_gate_core_test;

    localparam int WINDOW_LEN   = 8;
    localparam int MAX_GAP      = 19;
    localparam int SETTLE_TICKS = 16;
    localparam int STALL_LIMIT  = 3000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 150;

    // indexes that decode to no register
    localparam logic [pmbg_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [pmbg_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef enum int {
        WIN_TONE,
        WIN_FLAT,
        WIN_NOISE,
        WIN_CONTINUE,
        WIN_TRUNCATED,
        WIN_JITTER
    } window_kind_t;

    typedef struct packed {
        logic signed [pmbg_pkg::BIN_W-1:0] bin_real;
        logic signed [pmbg_pkg::BIN_W-1:0] bin_imag;
        logic [pmbg_pkg::POWER_W-1:0]      bin_power;
        logic [pmbg_pkg::AC_OUT_W-1:0]     ac_scaled;
        logic                              power_pass;
        logic                              purity_pass;
        logic                              detected;
    } gate_result_t;

    class bin_gate_scoreboard;
        logic [pmbg_pkg::POWMIN_W-1:0] power_floor;
        logic [pmbg_pkg::PURITY_W-1:0] purity_floor;
        int                  position;
        longint              cos_sum;
        longint              sin_sum;
        longint              level_sum;
        longint              energy_sum;
        gate_result_t        window_q[$];
        int                  failures;

        function new();
            power_floor  = pmbg_pkg::POWER_MIN_RST;
            purity_floor = pmbg_pkg::PURITY_MIN_RST;
            failures     = 0;
            restart_window();
        endfunction

        function void restart_window();
            position   = 0;
            cos_sum    = 0;
            sin_sum    = 0;
            level_sum  = 0;
            energy_sum = 0;
        endfunction

        function void set_register(logic [pmbg_pkg::CFG_IDX_W-1:0] idx,
                                   logic [pmbg_pkg::CFG_DAT_W-1:0] data);
            case (idx)
                pmbg_pkg::CFG_POWER_MIN:  power_floor  = data[pmbg_pkg::POWMIN_W-1:0];
                pmbg_pkg::CFG_PURITY_MIN: purity_floor = data[pmbg_pkg::PURITY_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic [pmbg_pkg::SAMPLE_W-1:0] level, logic start);
            longint            x;
            longint            pw;
            longint            ac;
            longint unsigned   lhs;
            longint unsigned   rhs;
            gate_result_t      res;
            x = longint'(level);
            if (start)
                restart_window();
            // bin 2 at eight samples: cos runs 1,0,-1,0 and -sin runs 0,-1,0,1
            case (position % 4)
                0: cos_sum += x;
                1: sin_sum -= x;
                2: cos_sum -= x;
                default: sin_sum += x;
            endcase
            level_sum  += x;
            energy_sum += x * x;
            if (position < WINDOW_LEN - 1)
            begin
                position++;
                return;
            end
            pw  = cos_sum * cos_sum + sin_sum * sin_sum;
            ac  = WINDOW_LEN * energy_sum - level_sum * level_sum;
            lhs = longint'(pw) << pmbg_pkg::PURITY_SHIFT;
            rhs = longint'(purity_floor) * longint'(ac);
            res.bin_real    = cos_sum[pmbg_pkg::BIN_W-1:0];
            res.bin_imag    = sin_sum[pmbg_pkg::BIN_W-1:0];
            res.bin_power   = pw[pmbg_pkg::POWER_W-1:0];
            res.ac_scaled   = ac[pmbg_pkg::AC_OUT_W-1:0];
            res.power_pass  = (pw > longint'(power_floor));
            res.purity_pass = (lhs > rhs);
            res.detected    = res.power_pass && res.purity_pass;
            window_q.push_back(res);
            restart_window();
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(gate_result_t got);
            gate_result_t want;
            if (window_q.size() == 0)
            begin
                $error("result arrived with no window outstanding");
                failures++;
                return;
            end
            want = window_q.pop_front();
            compare_field("bin_real", longint'($signed(want.bin_real)),
                          longint'($signed(got.bin_real)));
            compare_field("bin_imag", longint'($signed(want.bin_imag)),
                          longint'($signed(got.bin_imag)));
            compare_field("bin_power", want.bin_power, got.bin_power);
            compare_field("ac_scaled", want.ac_scaled, got.ac_scaled);
            compare_field("power_pass", want.power_pass, got.power_pass);
            compare_field("purity_pass", want.purity_pass, got.purity_pass);
            compare_field("detected", want.detected, got.detected);
        endfunction

        function int pending();
            return window_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    pmbg_in_if  samples_ch();
    pmbg_out_if results_ch();
    pmbg_cfg_if cfg_ch();

    pixel_modulation_bin_gate_core #(
        .WINDOW (WINDOW_LEN)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_ch),
        .results (results_ch),
        .cfg     (cfg_ch)
    );

    bin_gate_scoreboard sb = new();
    bit                 sender_steady = 1'b0;
    bit                 sink_steady   = 1'b0;
    int                 random_items;

    task automatic send_sample(input logic [pmbg_pkg::SAMPLE_W-1:0] level, input logic start);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            samples_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples_ch.valid        <= 1'b1;
        samples_ch.sample       <= level;
        samples_ch.window_start <= start;
        do @(posedge clk); while (!samples_ch.ready);
        sb.note_sample(level, start);
        random_items++;
    endtask

    // hold off until every window result is out and the block has gone quiet
    task automatic drain_block();
        samples_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic program_gates(input logic [pmbg_pkg::CFG_DAT_W-1:0] power_val,
                                 input logic [pmbg_pkg::CFG_DAT_W-1:0] purity_val,
                                 input bit poke_spare);
        logic [pmbg_pkg::CFG_IDX_W-1:0] idx [3];
        logic [pmbg_pkg::CFG_DAT_W-1:0] val [3];
        int                   count;
        idx[0] = pmbg_pkg::CFG_POWER_MIN;
        val[0] = power_val;
        idx[1] = ($urandom_range(0, 1) == 0) ? CFG_SPARE_LO : CFG_SPARE_HI;
        val[1] = pmbg_pkg::CFG_DAT_W'($urandom_range(0, (1 << pmbg_pkg::CFG_DAT_W) - 1));
        idx[2] = pmbg_pkg::CFG_PURITY_MIN;
        val[2] = purity_val;
        count  = 3;
        if (!poke_spare)
        begin
            idx[1] = idx[2];
            val[1] = val[2];
            count  = 2;
        end
        for (int i = 0; i < count; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[i];
            cfg_ch.data  <= val[i];
            do @(posedge clk); while (!cfg_ch.ready);
            sb.set_register(idx[i], val[i]);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [pmbg_pkg::SAMPLE_W-1:0] clip_level(int v);
        if (v < 0)
            return '0;
        if (v > 255)
            return 8'd255;
        return v[pmbg_pkg::SAMPLE_W-1:0];
    endfunction

    task automatic send_window(input window_kind_t kind);
        int base;
        int amp_cos;
        int amp_sin;
        int noise;
        int len;
        int v;
        logic start;
        base    = $urandom_range(0, 255);
        amp_cos = $urandom_range(0, 254) - 127;
        amp_sin = $urandom_range(0, 254) - 127;
        noise   = $urandom_range(0, 24);
        len     = (kind == WIN_TRUNCATED) ? $urandom_range(1, WINDOW_LEN - 1) : WINDOW_LEN;
        if ($urandom_range(0, 7) == 0)
            sender_steady = !sender_steady;
        for (int p = 0; p < len; p++)
        begin
            case (p % 4)
                0: v = base + amp_cos;
                1: v = base + amp_sin;
                2: v = base - amp_cos;
                default: v = base - amp_sin;
            endcase
            v = v + $urandom_range(0, 2 * noise) - noise;
            start = (p == 0) && (kind != WIN_CONTINUE);
            case (kind)
                WIN_FLAT:   v = base;
                WIN_NOISE:  v = $urandom_range(0, 255);
                WIN_JITTER:
                begin
                    v = $urandom_range(0, 255);
                    start = ($urandom_range(0, 5) == 0);
                end
                default: ;
            endcase
            send_sample(clip_level(v), start);
        end
    endtask

    function automatic window_kind_t pick_kind();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return WIN_TONE;
            5:             return WIN_FLAT;
            6:             return WIN_NOISE;
            7:             return WIN_CONTINUE;
            8:             return WIN_TRUNCATED;
            default:       return WIN_JITTER;
        endcase
    endfunction

    // result sink with random stalls and stretches of none
    initial
    begin
        int           stall;
        gate_result_t got;
        results_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 5) == 0)
                sink_steady = !sink_steady;
            stall = sink_steady ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                results_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            results_ch.ready <= 1'b1;
            do @(posedge clk); while (!results_ch.valid);
            got.bin_real    = results_ch.bin_real;
            got.bin_imag    = results_ch.bin_imag;
            got.bin_power   = results_ch.bin_power;
            got.ac_scaled   = results_ch.ac_scaled;
            got.power_pass  = results_ch.power_pass;
            got.purity_pass = results_ch.purity_pass;
            got.detected    = results_ch.detected;
            sb.check_result(got);
        end
    end

    // watchdog on cycles with no request moving on any channel
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((samples_ch.valid && samples_ch.ready) || (results_ch.valid && results_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("pixel_modulation_bin_gate_core verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        logic [pmbg_pkg::CFG_DAT_W-1:0] power_val;
        logic [pmbg_pkg::CFG_DAT_W-1:0] purity_val;
        rst_n                   <= 1'b0;
        samples_ch.valid        <= 1'b0;
        samples_ch.sample       <= '0;
        samples_ch.window_start <= 1'b0;
        cfg_ch.valid            <= 1'b0;
        cfg_ch.index            <= pmbg_pkg::CFG_POWER_MIN;
        cfg_ch.data             <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: dropped partial window, largest positive and negative bins, flat window
        random_items = 0;
        send_sample(8'd17, 1'b1);
        send_sample(8'd200, 1'b0);
        send_sample(8'd255, 1'b0);
        send_sample(8'd255, 1'b1);
        send_sample(8'd0, 1'b0);
        send_sample(8'd0, 1'b0);
        send_sample(8'd255, 1'b0);
        send_sample(8'd255, 1'b0);
        send_sample(8'd0, 1'b0);
        send_sample(8'd0, 1'b0);
        send_sample(8'd255, 1'b0);
        // next window follows without a start mark
        send_sample(8'd0, 1'b0);
        send_sample(8'd255, 1'b0);
        send_sample(8'd255, 1'b0);
        send_sample(8'd0, 1'b0);
        send_sample(8'd0, 1'b0);
        send_sample(8'd255, 1'b0);
        send_sample(8'd255, 1'b0);
        send_sample(8'd0, 1'b0);
        for (int p = 0; p < WINDOW_LEN; p++)
            send_sample(8'd255, p == 0);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_block();
            case (phase)
                0:
                begin
                    power_val  = '0;
                    purity_val = '0;
                end
                1:
                begin
                    power_val  = 20'hFFFFF;
                    purity_val = {3'b111, 17'h1FFFF};
                end
                2:
                begin
                    power_val  = '0;
                    purity_val = 20'd65536;
                end
                3:
                begin
                    power_val  = 20'd1000;
                    purity_val = 20'd32768;
                end
                4:
                begin
                    power_val  = 20'd520199;
                    purity_val = 20'd1;
                end
                5:
                begin
                    power_val  = pmbg_pkg::CFG_DAT_W'($urandom_range(0, 50000));
                    purity_val = pmbg_pkg::CFG_DAT_W'($urandom_range(0, 65536));
                end
                6:
                begin
                    power_val  = pmbg_pkg::CFG_DAT_W'($urandom_range(0, 20'hFFFFF));
                    purity_val = pmbg_pkg::CFG_DAT_W'($urandom_range(0, 20'hFFFFF));
                end
                default:
                begin
                    power_val  = pmbg_pkg::CFG_DAT_W'($urandom_range(0, 5000));
                    purity_val = pmbg_pkg::CFG_DAT_W'({$urandom_range(0, 7), 17'd0}
                                                      + $urandom_range(16384, 65536));
                end
            endcase
            program_gates(power_val, purity_val, phase % 3 == 1);
            random_items = 0;
            while (random_items < PHASE_ITEMS)
                send_window(pick_kind());
        end

        drain_block();
        if (sb.failures == 0 && sb.pending() == 0)
            $display("pixel_modulation_bin_gate_core verification clean");
        else
            $display("pixel_modulation_bin_gate_core verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/pmbg_pkg.sv
hdl/pmbg_if.sv
hdl/pmbg_mul.sv
hdl/pmbg_rom.sv
hdl/pixel_modulation_bin_gate_core.sv
tb/pixel_modulation_bin_gate_core_test.sv
